>>> sv/plpe_pkg.sv
// Shared constants and register codes for the lidar plane point extractor.
// No dependencies; every other file imports this package.
package plpe_pkg;

   // Parameter defaults
   localparam int MAX_RINGS_DEF   = 128;
   localparam int HALF_WINDOW_DEF = 5;
   localparam int COORD_BITS_DEF  = 18;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int OUT_DEPTH_DEF   = 8;

   // Configuration register widths
   localparam int RING_CNT_W  = 8;
   localparam int RANGE_SQ_W  = 36;
   localparam int THRESHOLD_W = 48;
   localparam int REFL_W      = 8;
   localparam int RING_ID_W   = 8;

   // Register reset values
   localparam logic [RING_CNT_W-1:0]  RING_COUNT_RST = RING_CNT_W'(16);
   localparam logic [RANGE_SQ_W-1:0]  MIN_RANGE_RST  = RANGE_SQ_W'(250000);
   localparam logic [RANGE_SQ_W-1:0]  MAX_RANGE_RST  = RANGE_SQ_W'(400000000);
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST  = THRESHOLD_W'(100000);

   // APB port geometry: 64-bit registers at 8-byte strides
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      REG_RING_COUNT = 2'd0,
      REG_MIN_RANGE  = 2'd1,
      REG_MAX_RANGE  = 2'd2,
      REG_PLANE_THR  = 2'd3
   } csr_reg_type;

endpackage

>>> sv/plpe_if.sv
// Point (request) and plane point (response) channel interfaces.
// Depends on plpe_pkg for default widths.
interface plpe_req_if import plpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_BITS-1:0]  pos_x;
   logic [COORD_BITS-1:0]  pos_y;
   logic [COORD_BITS-1:0]  pos_z;
   logic [REFL_W-1:0]      reflect;
   logic [RING_ID_W-1:0]   ring_id;
   logic                   frame_end;

   modport source (output valid, pos_x, pos_y, pos_z, reflect, ring_id, frame_end,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, reflect, ring_id, frame_end,
                   output ready);
endinterface

interface plpe_rsp_if import plpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int RING_BITS  = 7
) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_BITS-1:0]  out_x;
   logic [COORD_BITS-1:0]  out_y;
   logic [COORD_BITS-1:0]  out_z;
   logic [REFL_W-1:0]      out_reflect;
   logic [RING_BITS-1:0]   out_ring;

   modport source (output valid, out_x, out_y, out_z, out_reflect, out_ring,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_reflect, out_ring,
                   output ready);
endinterface

>>> sv/plpe_fifo.sv
// Small flop-based FIFO used for the classified-point queue and the result buffer.
// Depends on plpe_pkg (import only); DEPTH must be a power of two.
module plpe_fifo import plpe_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   // upstream credit logic must never overrun or underrun the buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)))
      else $error("fifo push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("fifo pop while empty");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff))
      else $error("fifo pointers disagree with count");

endmodule

>>> sv/plpe_front.sv
// Front end: registers incoming points, squares the coordinates, range and ring
// checks, then pushes a classified word into the queue. Depends on plpe_pkg.
module plpe_front import plpe_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int MAX_RINGS   = MAX_RINGS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1,
   localparam int ITEM_W = 3 * COORD_BITS + REFL_W + RING_W + 2,
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   plpe_req_if.sink               req_if,
   input  logic [RING_CNT_W-1:0]  ring_count,
   input  logic [RANGE_SQ_W-1:0]  min_range_sq,
   input  logic [RANGE_SQ_W-1:0]  max_range_sq,
   input  logic [QCNT_W-1:0]      q_count,
   output logic                   q_push,
   output logic [ITEM_W-1:0]      q_data
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int R2_W  = SQ_W + 2;
   localparam int CMP_W = (R2_W > RANGE_SQ_W) ? R2_W : RANGE_SQ_W;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [REFL_W-1:0]     refl;
      logic [RING_W-1:0]     ring;
      logic                  keep;
      logic                  fe;
   } item_type;

   // stage 1: raw point
   logic                         f1_v_ff;
   logic signed [COORD_BITS-1:0] f1_x_ff, f1_y_ff, f1_z_ff;
   logic [REFL_W-1:0]            f1_refl_ff;
   logic [RING_ID_W-1:0]         f1_ring_ff;
   logic                         f1_fe_ff;

   // stage 2: squares
   logic                         f2_v_ff;
   logic [COORD_BITS-1:0]        f2_x_ff, f2_y_ff, f2_z_ff;
   logic [REFL_W-1:0]            f2_refl_ff;
   logic [RING_ID_W-1:0]         f2_ring_ff;
   logic                         f2_fe_ff;
   logic [SQ_W-1:0]              f2_sqx_ff, f2_sqy_ff, f2_sqz_ff;

   logic signed [SQ_W-1:0]       sqx_in, sqy_in, sqz_in;
   logic [CMP_W-1:0]             r2;
   logic                         ring_ok, range_ok;
   logic                         accept;
   item_type                     item;

   // credit: queue plus words still in the front stages
   assign req_if.ready = (QCNT_W'(q_count) + QCNT_W'(f1_v_ff) + QCNT_W'(f2_v_ff))
                         < QCNT_W'(QUEUE_DEPTH);
   assign accept = req_if.valid & req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept;
         f2_v_ff <= f1_v_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      f1_x_ff    <= req_if.pos_x;
      f1_y_ff    <= req_if.pos_y;
      f1_z_ff    <= req_if.pos_z;
      f1_refl_ff <= req_if.reflect;
      f1_ring_ff <= req_if.ring_id;
      f1_fe_ff   <= req_if.frame_end;

      f2_x_ff    <= f1_x_ff;
      f2_y_ff    <= f1_y_ff;
      f2_z_ff    <= f1_z_ff;
      f2_refl_ff <= f1_refl_ff;
      f2_ring_ff <= f1_ring_ff;
      f2_fe_ff   <= f1_fe_ff;
      f2_sqx_ff  <= sqx_in;
      f2_sqy_ff  <= sqy_in;
      f2_sqz_ff  <= sqz_in;
   end

   // squared coordinates
   always_comb begin
      sqx_in = f1_x_ff * f1_x_ff;
      sqy_in = f1_y_ff * f1_y_ff;
      sqz_in = f1_z_ff * f1_z_ff;
   end

   // squared range and ring checks
   always_comb begin
      r2 = CMP_W'(f2_sqx_ff) + CMP_W'(f2_sqy_ff) + CMP_W'(f2_sqz_ff);
      range_ok = (r2 >= CMP_W'(min_range_sq)) && (r2 <= CMP_W'(max_range_sq));
      ring_ok  = (f2_ring_ff < ring_count) &&
                 ({1'b0, f2_ring_ff} < (RING_ID_W + 1)'(MAX_RINGS));
      item.x    = f2_x_ff;
      item.y    = f2_y_ff;
      item.z    = f2_z_ff;
      item.refl = f2_refl_ff;
      item.ring = RING_W'(f2_ring_ff);
      item.keep = range_ok & ring_ok;
      item.fe   = f2_fe_ff;
   end

   assign q_push = f2_v_ff;
   assign q_data = item;

endmodule

>>> sv/plpe_back.sv
// Back end: per-ring window memory, running window sums, curvature and threshold.
// Depends on plpe_pkg; fed from the classified-point queue.
module plpe_back import plpe_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int MAX_RINGS   = MAX_RINGS_DEF,
   parameter int HALF_WINDOW = HALF_WINDOW_DEF,
   parameter int OUT_DEPTH   = OUT_DEPTH_DEF,
   localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1,
   localparam int ITEM_W = 3 * COORD_BITS + REFL_W + RING_W + 2,
   localparam int RES_W  = 3 * COORD_BITS + REFL_W + RING_W,
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [THRESHOLD_W-1:0] plane_threshold,
   input  logic                   q_valid,
   input  logic [ITEM_W-1:0]      q_data,
   output logic                   q_pop,
   input  logic [OCNT_W-1:0]      o_count,
   output logic                   o_push,
   output logic [RES_W-1:0]       o_data
);

   localparam int WIN   = 2 * HALF_WINDOW + 1;
   localparam int HF_W  = $clog2(WIN + 1);
   localparam int SUM_W = COORD_BITS + $clog2(WIN);
   localparam int D_W   = SUM_W + 1;
   localparam int SQ_W  = 2 * D_W;
   localparam int CV_W  = SQ_W + 2;
   localparam int CMP_W = (CV_W > THRESHOLD_W) ? CV_W : THRESHOLD_W;
   localparam int WA_W  = $clog2(MAX_RINGS * WIN);
   localparam int SG_W  = 3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [REFL_W-1:0]     refl;
      logic [RING_W-1:0]     ring;
      logic                  keep;
      logic                  fe;
   } item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [REFL_W-1:0]     refl;
   } pt_type;

   typedef struct packed {
      logic [SUM_W-1:0] sx;
      logic [SUM_W-1:0] sy;
      logic [SUM_W-1:0] sz;
   } sum_type;

   typedef struct packed {
      logic [HF_W-1:0] head;
      logic [HF_W-1:0] fill;
   } hf_type;

   // memories
   pt_type   win_mem [MAX_RINGS * WIN];
   hf_type   hf_mem  [MAX_RINGS];
   sum_type  sum_mem [MAX_RINGS];
   logic [MAX_RINGS-1:0] valid_ff;

   item_type q_item;
   assign q_item = q_data;

   // stage A: head/fill lookup, window access
   logic            a_v_ff;
   item_type        a_ff;
   hf_type          hf_rd_ff;
   logic            fwd_hf;
   hf_type          hf_old;
   logic [HF_W-1:0] head_cur, head_nxt, fill_nxt, mid_slot;
   logic [HF_W:0]   mid_sum;
   logic [WA_W-1:0] wr_addr, mid_addr;
   logic            a_write;

   // stage B: running sum update
   logic            b_v_ff, b_keep_ff, b_fe_ff, b_evict_ff, b_fresh_ff, b_full_ff;
   logic [RING_W-1:0] b_ring_ff;
   logic [HF_W-1:0] b_head_ff, b_fill_ff;
   logic [COORD_BITS-1:0] b_x_ff, b_y_ff, b_z_ff;
   pt_type          evict_rd_ff, mid_rd_ff;
   sum_type         sum_rd_ff;
   sum_type         s_old, s_new;
   logic            fwd_sum;

   // stage C: deviation from the window mean
   logic            c_v_ff, c_keep_ff, c_cand_ff;
   logic [RING_W-1:0] c_ring_ff;
   sum_type         c_sum_ff;
   pt_type          c_mid_ff;
   logic [D_W-1:0]  dx_in, dy_in, dz_in;

   // stage D: squares
   logic            d_v_ff, d_cand_ff;
   logic [RING_W-1:0] d_ring_ff;
   pt_type          d_mid_ff;
   logic signed [D_W-1:0]  d_x_ff, d_y_ff, d_z_ff;
   logic signed [SQ_W-1:0] qx_in, qy_in, qz_in;

   // stage E: threshold compare
   logic            e_v_ff, e_cand_ff;
   logic [RING_W-1:0] e_ring_ff;
   pt_type          e_mid_ff;
   logic [SQ_W-1:0] e_qx_ff, e_qy_ff, e_qz_ff;
   logic [CMP_W-1:0] curv;

   logic [SG_W-1:0] inflight;

   // pop only when the result buffer can absorb everything in flight
   assign inflight = SG_W'(a_v_ff) + SG_W'(b_v_ff) + SG_W'(c_v_ff)
                   + SG_W'(d_v_ff) + SG_W'(e_v_ff);
   assign q_pop = q_valid &&
      ((OCNT_W + SG_W)'(o_count) + (OCNT_W + SG_W)'(inflight)
       < (OCNT_W + SG_W)'(OUT_DEPTH));

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         e_v_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         a_v_ff <= q_pop;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         // frame end clears every ring after its own point is handled
         if (a_v_ff && a_ff.fe) begin
            valid_ff <= '0;
         end else if (a_write) begin
            valid_ff[a_ff.ring] <= 1'b1;
         end
      end
   end

   // stage A logic
   always_comb begin
      fwd_hf = b_v_ff && b_keep_ff && !b_fe_ff && (b_ring_ff == a_ff.ring);
      if (fwd_hf) begin
         hf_old.head = b_head_ff;
         hf_old.fill = b_fill_ff;
      end else if (valid_ff[a_ff.ring]) begin
         hf_old = hf_rd_ff;
      end else begin
         hf_old = '0;
      end
      head_cur = (hf_old.head >= HF_W'(WIN)) ? '0 : hf_old.head;
      head_nxt = (head_cur == HF_W'(WIN - 1)) ? '0 : head_cur + HF_W'(1);
      fill_nxt = (hf_old.fill >= HF_W'(WIN)) ? HF_W'(WIN) : hf_old.fill + HF_W'(1);
      mid_sum  = {1'b0, head_nxt} + (HF_W + 1)'(HALF_WINDOW);
      mid_slot = (mid_sum >= (HF_W + 1)'(WIN)) ? HF_W'(mid_sum - (HF_W + 1)'(WIN))
                                                : HF_W'(mid_sum);
      wr_addr  = WA_W'(a_ff.ring) * WA_W'(WIN) + WA_W'(head_cur);
      mid_addr = WA_W'(a_ff.ring) * WA_W'(WIN) + WA_W'(mid_slot);
      a_write  = a_v_ff && a_ff.keep;
   end

   // memory ports: write at the head, read the evicted and middle slots
   always_ff @(posedge clock) begin
      hf_rd_ff <= hf_mem[q_item.ring];
      if (a_write) begin
         win_mem[wr_addr]   <= {a_ff.x, a_ff.y, a_ff.z, a_ff.refl};
         hf_mem[a_ff.ring]  <= {head_nxt, fill_nxt};
      end
      evict_rd_ff <= win_mem[wr_addr];
      mid_rd_ff   <= win_mem[mid_addr];
      sum_rd_ff   <= sum_mem[a_ff.ring];
      if (b_v_ff && b_keep_ff) begin
         sum_mem[b_ring_ff] <= s_new;
      end
   end

   // stage B logic: sum += new point - evicted point
   always_comb begin
      fwd_sum = c_v_ff && c_keep_ff && (c_ring_ff == b_ring_ff);
      if (b_fresh_ff) begin
         s_old = '0;
      end else if (fwd_sum) begin
         s_old = c_sum_ff;
      end else begin
         s_old = sum_rd_ff;
      end
      s_new.sx = s_old.sx + SUM_W'($signed(b_x_ff));
      s_new.sy = s_old.sy + SUM_W'($signed(b_y_ff));
      s_new.sz = s_old.sz + SUM_W'($signed(b_z_ff));
      if (b_evict_ff) begin
         s_new.sx = s_new.sx - SUM_W'($signed(evict_rd_ff.x));
         s_new.sy = s_new.sy - SUM_W'($signed(evict_rd_ff.y));
         s_new.sz = s_new.sz - SUM_W'($signed(evict_rd_ff.z));
      end
   end

   // stage C logic: full-window sum minus WIN times the middle point
   always_comb begin
      dx_in = D_W'($signed(c_sum_ff.sx)) - D_W'($signed(c_mid_ff.x)) * D_W'(WIN);
      dy_in = D_W'($signed(c_sum_ff.sy)) - D_W'($signed(c_mid_ff.y)) * D_W'(WIN);
      dz_in = D_W'($signed(c_sum_ff.sz)) - D_W'($signed(c_mid_ff.z)) * D_W'(WIN);
   end

   // stage D logic
   always_comb begin
      qx_in = d_x_ff * d_x_ff;
      qy_in = d_y_ff * d_y_ff;
      qz_in = d_z_ff * d_z_ff;
   end

   // stage E logic
   assign curv = CMP_W'(e_qx_ff) + CMP_W'(e_qy_ff) + CMP_W'(e_qz_ff);
   assign o_push = e_v_ff && e_cand_ff && (curv < CMP_W'(plane_threshold));
   assign o_data = {e_mid_ff.x, e_mid_ff.y, e_mid_ff.z, e_mid_ff.refl, e_ring_ff};

   // payload pipeline registers
   always_ff @(posedge clock) begin
      a_ff       <= q_item;

      b_keep_ff  <= a_ff.keep;
      b_fe_ff    <= a_ff.fe;
      b_ring_ff  <= a_ff.ring;
      b_head_ff  <= head_nxt;
      b_fill_ff  <= fill_nxt;
      b_evict_ff <= (hf_old.fill >= HF_W'(WIN));
      b_fresh_ff <= (hf_old.fill == '0);
      b_full_ff  <= (fill_nxt == HF_W'(WIN));
      b_x_ff     <= a_ff.x;
      b_y_ff     <= a_ff.y;
      b_z_ff     <= a_ff.z;

      c_keep_ff  <= b_keep_ff;
      c_cand_ff  <= b_keep_ff && b_full_ff;
      c_ring_ff  <= b_ring_ff;
      c_sum_ff   <= s_new;
      c_mid_ff   <= mid_rd_ff;

      d_cand_ff  <= c_cand_ff;
      d_ring_ff  <= c_ring_ff;
      d_mid_ff   <= c_mid_ff;
      d_x_ff     <= dx_in;
      d_y_ff     <= dy_in;
      d_z_ff     <= dz_in;

      e_cand_ff  <= d_cand_ff;
      e_ring_ff  <= d_ring_ff;
      e_mid_ff   <= d_mid_ff;
      e_qx_ff    <= qx_in;
      e_qy_ff    <= qy_in;
      e_qz_ff    <= qz_in;
   end

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (a_v_ff && a_ff.fe) |=> (valid_ff == '0))
      else $error("frame end did not clear ring state");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (b_v_ff && b_keep_ff) |-> (b_head_ff < HF_W'(WIN) && b_fill_ff <= HF_W'(WIN)))
      else $error("ring head or fill out of range");

endmodule

>>> sv/lidar_plane_point_extractor_top.sv
// An accepted point reaches rsp_if as a plane point through 2 front stages, the queue,
// 5 back stages and the result buffer; a dropped point yields nothing.
// Throughput: one point per cycle while queue credit and rsp_if.ready allow; the back
// end writes the window and running-sum memories once per kept point.
// Reset (synchronous, active high) restores register defaults and empties ring
// fill state through per-ring valid flops at once; no clearing pass is needed.
module lidar_plane_point_extractor_top import plpe_pkg::*; #(
   parameter int MAX_RINGS   = MAX_RINGS_DEF,
   parameter int HALF_WINDOW = HALF_WINDOW_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   plpe_req_if.sink               req_if,
   plpe_rsp_if.source             rsp_if,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int ITEM_W = 3 * COORD_BITS + REFL_W + RING_W + 2;
   localparam int RES_W  = 3 * COORD_BITS + REFL_W + RING_W;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH_DEF + 1);
   localparam int OCNT_W = $clog2(OUT_DEPTH_DEF + 1);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [REFL_W-1:0]     refl;
      logic [RING_W-1:0]     ring;
   } res_type;

   // configuration registers
   logic [RING_CNT_W-1:0]  ring_count_ff;
   logic [RANGE_SQ_W-1:0]  min_range_ff;
   logic [RANGE_SQ_W-1:0]  max_range_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;
   csr_reg_type            csr_sel;
   logic                   csr_wr;

   assign csr_sel = csr_reg_type'(paddr[4:3]);
   assign csr_wr  = psel & penable & pwrite & pready;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff <= RING_COUNT_RST;
         min_range_ff  <= MIN_RANGE_RST;
         max_range_ff  <= MAX_RANGE_RST;
         threshold_ff  <= THRESHOLD_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_RING_COUNT: ring_count_ff <= pwdata[RING_CNT_W-1:0];
            REG_MIN_RANGE:  min_range_ff  <= pwdata[RANGE_SQ_W-1:0];
            REG_MAX_RANGE:  max_range_ff  <= pwdata[RANGE_SQ_W-1:0];
            REG_PLANE_THR:  threshold_ff  <= pwdata[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_sel)
         REG_RING_COUNT: prdata = CSR_DATA_W'(ring_count_ff);
         REG_MIN_RANGE:  prdata = CSR_DATA_W'(min_range_ff);
         REG_MAX_RANGE:  prdata = CSR_DATA_W'(max_range_ff);
         REG_PLANE_THR:  prdata = CSR_DATA_W'(threshold_ff);
         default:        prdata = '0;
      endcase
   end

   // front end and classified-word queue
   logic              q_push, q_pop, q_valid;
   logic [ITEM_W-1:0] q_in, q_out;
   logic [QCNT_W-1:0] q_count;

   plpe_front #(
      .COORD_BITS  (COORD_BITS),
      .MAX_RINGS   (MAX_RINGS),
      .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .ring_count   (ring_count_ff),
      .min_range_sq (min_range_ff),
      .max_range_sq (max_range_ff),
      .q_count      (q_count),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   plpe_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_out),
      .count     (q_count)
   );

   // back end and result buffer
   logic              o_push, o_pop, o_valid;
   logic [RES_W-1:0]  o_in, o_out;
   logic [OCNT_W-1:0] o_count;
   res_type           res;

   plpe_back #(
      .COORD_BITS  (COORD_BITS),
      .MAX_RINGS   (MAX_RINGS),
      .HALF_WINDOW (HALF_WINDOW),
      .OUT_DEPTH   (OUT_DEPTH_DEF)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .plane_threshold (threshold_ff),
      .q_valid         (q_valid),
      .q_data          (q_out),
      .q_pop           (q_pop),
      .o_count         (o_count),
      .o_push          (o_push),
      .o_data          (o_in)
   );

   plpe_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH_DEF)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_in),
      .pop       (o_pop),
      .out_valid (o_valid),
      .out_data  (o_out),
      .count     (o_count)
   );

   assign res                = o_out;
   assign o_pop              = o_valid & rsp_if.ready;
   assign rsp_if.valid       = o_valid;
   assign rsp_if.out_x       = res.x;
   assign rsp_if.out_y       = res.y;
   assign rsp_if.out_z       = res.z;
   assign rsp_if.out_reflect = res.refl;
   assign rsp_if.out_ring    = res.ring;

endmodule

>>> tb/sv/lidar_plane_point_extractor_top_test.sv
// Testbench for the lidar plane point extractor: drives points, predicts plane points.
// Depends on plpe_pkg, plpe_if and lidar_plane_point_extractor_top.
`timescale 1ns / 1ps
module lidar_plane_point_extractor_top_test;
   import plpe_pkg::*;

   localparam int WIN    = 2 * HALF_WINDOW_DEF + 1;
   localparam int LIMIT  = 2000000;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
      logic [7:0]         refl;
      logic [7:0]         ring;
      logic               fend;
   } point_type;

   typedef struct packed {
      logic [17:0] x;
      logic [17:0] y;
      logic [17:0] z;
      logic [7:0]  refl;
      logic [6:0]  ring;
   } plane_type;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   plpe_req_if req_if();
   plpe_rsp_if rsp_if();

   lidar_plane_point_extractor_top dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  ring_count_q;
   logic [35:0] min_rsq_q, max_rsq_q;
   logic [47:0] thresh_q;
   point_type   win_mem [128][WIN];
   int          fill_q [128];
   int          head_q [128];
   plane_type   plane_q[$];

   int errors = 0;
   int cycles = 0;
   bit rx_stall_mode = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   // squared range / curvature model, exact in 64-bit
   function automatic longint unsigned sqr(input longint v);
      return v * v;
   endfunction

   task automatic predict_point(input point_type p);
      longint unsigned r2, curv;
      longint sx, sy, sz;
      int r, h, mid;
      plane_type hit;
      r2 = sqr(p.x) + sqr(p.y) + sqr(p.z);
      r = p.ring;
      if (r2 >= min_rsq_q && r2 <= max_rsq_q && p.ring < ring_count_q && r < 128) begin
         h = head_q[r];
         win_mem[r][h] = p;
         h = (h + 1) % WIN;
         head_q[r] = h;
         if (fill_q[r] < WIN) fill_q[r]++;
         if (fill_q[r] >= WIN) begin
            mid = (h + HALF_WINDOW_DEF) % WIN;
            sx = 0; sy = 0; sz = 0;
            for (int k = 0; k < WIN; k++) begin
               if (k != mid) begin
                  sx += win_mem[r][k].x;
                  sy += win_mem[r][k].y;
                  sz += win_mem[r][k].z;
               end
            end
            sx -= 10 * longint'(win_mem[r][mid].x);
            sy -= 10 * longint'(win_mem[r][mid].y);
            sz -= 10 * longint'(win_mem[r][mid].z);
            curv = sqr(sx) + sqr(sy) + sqr(sz);
            if (curv < thresh_q) begin
               hit = {win_mem[r][mid].x, win_mem[r][mid].y, win_mem[r][mid].z,
                      win_mem[r][mid].refl, r[6:0]};
               plane_q.insert(plane_q.size(), hit);
            end
         end
      end
      if (p.fend) begin
         foreach (fill_q[i]) begin
            fill_q[i] = 0;
            head_q[i] = 0;
         end
      end
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         plane_type exp;
         if (plane_q.size() == 0) report("unexpected word", rsp_if.out_x, 0);
         else begin
            exp = plane_q.pop_front();
            if (rsp_if.out_x !== exp.x) report("out_x", rsp_if.out_x, exp.x);
            if (rsp_if.out_y !== exp.y) report("out_y", rsp_if.out_y, exp.y);
            if (rsp_if.out_z !== exp.z) report("out_z", rsp_if.out_z, exp.z);
            if (rsp_if.out_reflect !== exp.refl)
               report("out_reflect", rsp_if.out_reflect, exp.refl);
            if (rsp_if.out_ring !== exp.ring) report("out_ring", rsp_if.out_ring, exp.ring);
         end
      end
      if (rx_stall_mode) rsp_if.ready <= ($urandom_range(0, 3) != 0) && (cycles % 23 > 4);
      else rsp_if.ready <= 1'b1;
   end

   task automatic csr_write(input csr_reg_type idx, input logic [63:0] val);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= CSR_ADDR_W'(idx * 8); pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_RING_COUNT: ring_count_q = val[7:0];
         REG_MIN_RANGE:  min_rsq_q = val[35:0];
         REG_MAX_RANGE:  max_rsq_q = val[35:0];
         REG_PLANE_THR:  thresh_q = val[47:0];
      endcase
   endtask

   // one point word; valid drops only for a random gap ahead of a burst
   int burst_left = 0;
   task automatic send_point(input point_type p);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) == 0) begin
            req_if.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1;
      req_if.pos_x <= p.x; req_if.pos_y <= p.y; req_if.pos_z <= p.z;
      req_if.reflect <= p.refl; req_if.ring_id <= p.ring; req_if.frame_end <= p.fend;
      do @(posedge clock); while (!req_if.ready);
      predict_point(p);
   endtask

   task automatic drain();
      req_if.valid <= 0;
      burst_left = 0;
      while (plane_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic point_type near_point(input int base, input int ring, input bit fend);
      point_type p;
      p.x = 18'(2000 + base + $urandom_range(0, 3));
      p.y = 18'(1500 + $urandom_range(0, 3));
      p.z = 18'(-300 + $urandom_range(0, 3));
      p.refl = 8'($urandom);
      p.ring = 8'(ring);
      p.fend = fend;
      return p;
   endfunction

   function automatic point_type wild_point();
      point_type p;
      p.x = 18'($urandom); p.y = 18'($urandom); p.z = 18'($urandom);
      p.refl = 8'($urandom); p.ring = 8'($urandom);
      p.fend = ($urandom_range(0, 15) == 0);
      return p;
   endfunction

   // field extremes, range and ring boundaries, frame end
   task automatic test_directed();
      point_type p;
      p = '{x: 18'sh1FFFF, y: 0, z: 0, refl: 8'hFF, ring: 0, fend: 0};
      send_point(p);
      p = '{x: -18'sd131072, y: -18'sd131072, z: -18'sd131072, refl: 0, ring: 15, fend: 0};
      send_point(p);
      p = '{x: 500, y: 0, z: 0, refl: 1, ring: 16, fend: 0};   // ring out of range
      send_point(p);
      p = '{x: 500, y: 0, z: 0, refl: 2, ring: 255, fend: 0};
      send_point(p);
      p = '{x: 20000, y: 0, z: 0, refl: 3, ring: 1, fend: 0};  // max range boundary
      send_point(p);
      p = '{x: 0, y: 0, z: 499, refl: 4, ring: 1, fend: 0};    // just under min range
      send_point(p);
      for (int i = 0; i < 13; i++) send_point(near_point(0, 2, i == 12));
      p = '{x: 0, y: 0, z: 0, refl: 5, ring: 200, fend: 1};    // dropped point ends frame
      send_point(p);
      drain();
   endtask

   // curvature right at and around the threshold
   task automatic test_threshold();
      point_type p;
      csr_write(REG_PLANE_THR, 48'd100);   // flat line: middle offset of 1 mm gives 100
      for (int i = 0; i < 11; i++) begin
         p = '{x: 1000, y: 0, z: 0, refl: 8'(i), ring: 3, fend: 0};
         if (i == 5) p.x = 1001;
         send_point(p);
      end
      p = '{x: 1001, y: 0, z: 0, refl: 9, ring: 3, fend: 1};
      send_point(p);
      drain();
      csr_write(REG_PLANE_THR, 48'd101);
      for (int i = 0; i < 11; i++) begin
         p = '{x: 1000, y: 0, z: 0, refl: 8'(i), ring: 4, fend: i == 10};
         if (i == 5) p.x = 1001;
         send_point(p);
      end
      drain();
   endtask

   // register extremes: empty ring set, inverted ranges, all open
   task automatic test_registers();
      csr_write(REG_RING_COUNT, 0);
      for (int i = 0; i < 15; i++) send_point(near_point(0, 0, 0));
      drain();
      csr_write(REG_RING_COUNT, 128);
      csr_write(REG_MIN_RANGE, 36'd1000);
      csr_write(REG_MAX_RANGE, 36'd999);
      for (int i = 0; i < 15; i++) send_point(near_point(0, 127, i == 14));
      drain();
      csr_write(REG_MIN_RANGE, 0);
      csr_write(REG_MAX_RANGE, 36'hF_FFFF_FFFF);
      csr_write(REG_PLANE_THR, 48'hFFFF_FFFF_FFFF);
      for (int i = 0; i < 40; i++) send_point(wild_point());
      send_point('{x: 0, y: 0, z: 0, refl: 0, ring: 0, fend: 1});
      drain();
   endtask

   // random frames: mostly smooth rings interleaved, some noise
   task automatic test_random(input int items);
      int rings;
      rx_stall_mode = 1;
      rings = ring_count_q > 8 ? 8 : ring_count_q;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 9) == 0) send_point(wild_point());
         else send_point(near_point((n % 50) * 3, $urandom_range(0, rings - 1),
                                    $urandom_range(0, 199) == 0));
      end
      drain();
      rx_stall_mode = 0;
   endtask

   initial begin
      req_if.valid = 0;
      req_if.pos_x = 0; req_if.pos_y = 0; req_if.pos_z = 0;
      req_if.reflect = 0; req_if.ring_id = 0; req_if.frame_end = 0;
      ring_count_q = RING_COUNT_RST; min_rsq_q = MIN_RANGE_RST;
      max_rsq_q = MAX_RANGE_RST; thresh_q = THRESHOLD_RST;
      foreach (fill_q[i]) begin
         fill_q[i] = 0;
         head_q[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_threshold();
      test_registers();
      csr_write(REG_RING_COUNT, 16);
      csr_write(REG_MIN_RANGE, 36'd250000);
      csr_write(REG_MAX_RANGE, 36'd400000000);
      csr_write(REG_PLANE_THR, 48'd2000);
      test_random(800);
      csr_write(REG_RING_COUNT, 5);
      csr_write(REG_PLANE_THR, 48'd100000);
      test_random(800);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> sim.f
sv/plpe_pkg.sv
sv/plpe_if.sv
sv/plpe_fifo.sv
sv/plpe_front.sv
sv/plpe_back.sv
sv/lidar_plane_point_extractor_top.sv
tb/sv/lidar_plane_point_extractor_top_test.sv
